[rtl/cmsm_pkg.sv]
// ---------------------------------------------------------------------------
// Stub matcher package
// Request and result types, operation codes and status codes shared by the
// stub matcher modules.
// ---------------------------------------------------------------------------
package cmsm_pkg;

    // Field widths fixed by the request and result formats.
    localparam int OP_W       = 2;
    localparam int NODE_W     = 6;
    localparam int WANT_W     = 7;
    localparam int FRAC_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int STUBS_W    = 13;
    localparam int REJ_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_W-1:0] OP_PROPOSE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EDGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_BACKTRACK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKTRACKS  = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] MAX_BACKTRACKS_RST = 8'd90;

    // Rejects counter saturation value.
    localparam logic [REJ_W-1:0] REJ_SAT = 9'h1FF;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NODE_W-1:0] node_index;
        logic [WANT_W-1:0] wanted_degree;
        logic [FRAC_W-1:0] first_fraction;
        logic [FRAC_W-1:0] second_fraction;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   first_node;
        logic [NODE_W-1:0]   second_node;
        logic [STUBS_W-1:0]  stubs_left;
        logic [REJ_W-1:0]    rejects_so_far;
        logic                matching_over;
        logic                restart_needed;
    } result_t;

endpackage

[rtl/configuration_model_stub_matcher.sv]
// ---------------------------------------------------------------------------
// Configuration-model stub matcher
// Holds remaining stub counts and an adjacency matrix, and matches random
// stub pairs into a simple graph, one request at a time.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the result has been produced, and the result is shown on result for
// exactly one cycle with done high, so the receiver must take it then. A
// proposal draws each of its two stubs by one shared multiply and a scan
// of the stub table at one entry per cycle through its read port, followed
// by the adjacency read and check and then either the write-back states or,
// on a reject with backtracking, the stub restore states. A load reads the
// old count and then writes the new one. A clear sweeps both tables at one
// row per cycle; the same sweep runs after reset and keeps busy high.
// Configuration writes are taken at any time and are meant to be made
// while the block is idle.
// ---------------------------------------------------------------------------
module configuration_model_stub_matcher #(
    parameter int NODES      = 64,
    parameter int MAX_DEGREE = 100
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  cmsm_pkg::request_t               request,
    output logic                             done,
    output cmsm_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [cmsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import cmsm_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int DEG_W = $clog2(MAX_DEGREE + 1);
    localparam int TOT_W = $clog2(NODES * MAX_DEGREE + 1);

    localparam logic [IDX_W-1:0] LAST    = IDX_W'(NODES - 1);
    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_DEGREE);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_LOAD_RD = 4'd2;
    localparam logic [3:0] S_LOAD_WR = 4'd3;
    localparam logic [3:0] S_PICK1   = 4'd4;
    localparam logic [3:0] S_PICK2   = 4'd5;
    localparam logic [3:0] S_ADJ_RD  = 4'd6;
    localparam logic [3:0] S_ADJ_CHK = 4'd7;
    localparam logic [3:0] S_ADJ_WR2 = 4'd8;
    localparam logic [3:0] S_REST1   = 4'd9;
    localparam logic [3:0] S_REST2   = 4'd10;
    localparam logic [3:0] S_FINISH  = 4'd11;

    // Control registers.
    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                  clr_item_reg, clr_item_next;
    logic                  prop_reg, prop_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [REJ_W-1:0]      rej_reg, rej_next;
    logic                  ended_reg, ended_next;
    logic                  done_reg, done_next;
    logic                  allow_reg;
    logic [CFG_DATA_W-1:0] maxbt_reg;

    // Payload registers.
    request_t              req_reg, req_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [IDX_W-1:0]      n1_reg, n1_next;
    logic [IDX_W-1:0]      n2_reg, n2_next;
    logic [DEG_W-1:0]      v1_reg, v1_next;
    logic [DEG_W-1:0]      v2_reg, v2_next;
    result_t               result_reg, result_next;

    // Memory ports.
    logic                  stub_we;
    logic [IDX_W-1:0]      stub_wa, stub_ra;
    logic [DEG_W-1:0]      stub_wd, stub_rd;
    logic                  adj_we;
    logic [IDX_W-1:0]      adj_wa, adj_ra;
    logic [NODES-1:0]      adj_wd, adj_rd;

    // Picker interface.
    logic                  pick_go;
    logic [FRAC_W-1:0]     pick_frac;
    logic [IDX_W-1:0]      pick_ra;
    logic                  pick_done;
    logic [IDX_W-1:0]      pick_node;

    // Derived values.
    logic [REJ_W-1:0]      limit;
    logic                  may_continue;
    logic                  load_in_range;
    logic [DEG_W-1:0]      deg_sat;
    logic [DEG_W-1:0]      taken;
    logic                  take_ok;
    logic                  inc1, inc2;
    logic [DEG_W-1:0]      same_a, same_b;
    logic [NODES-1:0]      bit_n1, bit_n2;
    logic                  linked;

    cmsm_ram #(
        .WIDTH (DEG_W),
        .DEPTH (NODES)
    ) u_stub_ram (
        .clk     (clk),
        .wr_en   (stub_we),
        .wr_addr (stub_wa),
        .wr_data (stub_wd),
        .rd_addr (stub_ra),
        .rd_data (stub_rd)
    );

    cmsm_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (adj_we),
        .wr_addr (adj_wa),
        .wr_data (adj_wd),
        .rd_addr (adj_ra),
        .rd_data (adj_rd)
    );

    cmsm_picker #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_picker (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (pick_go),
        .frac    (pick_frac),
        .total   (total_reg),
        .rd_data (stub_rd),
        .rd_addr (pick_ra),
        .done    (pick_done),
        .pick    (pick_node)
    );

    // Matching may go on while more than three stubs are left and the
    // reject count is below its limit.
    assign limit        = REJ_W'(1) + (allow_reg ? REJ_W'(maxbt_reg) : '0);
    assign may_continue = (total_reg > TOT_W'(3)) && (rej_reg < limit);

    assign load_in_range = 32'(req_reg.node_index) < NODES;
    assign deg_sat       = (32'(req_reg.wanted_degree) > MAX_DEGREE) ?
                           DEG_MAX : DEG_W'(req_reg.wanted_degree);

    // A drawn stub is taken only when the node still has one.
    assign take_ok = (stub_rd != '0);
    assign taken   = take_ok ? stub_rd - 1'b1 : stub_rd;

    // Restoring both stubs of a pair drawn twice from one node.
    assign inc1   = (v2_reg < DEG_MAX);
    assign same_a = inc1 ? v2_reg + 1'b1 : v2_reg;
    assign inc2   = (same_a < DEG_MAX);
    assign same_b = inc2 ? same_a + 1'b1 : same_a;

    assign bit_n1 = {{(NODES-1){1'b0}}, 1'b1} << n1_reg;
    assign bit_n2 = {{(NODES-1){1'b0}}, 1'b1} << n2_reg;
    assign linked = adj_rd[n2_reg];

    assign pick_go   = (state_reg == S_PICK1) || (state_reg == S_PICK2);
    assign pick_frac = (state_reg == S_PICK1) ? req_reg.first_fraction
                                              : req_reg.second_fraction;

    // Request sequencer.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_item_next = clr_item_reg;
        prop_next     = prop_reg;
        total_next    = total_reg;
        rej_next      = rej_reg;
        ended_next    = ended_reg;
        done_next     = 1'b0;
        req_next      = req_reg;
        status_next   = status_reg;
        n1_next       = n1_reg;
        n2_next       = n2_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        result_next   = result_reg;
        stub_we       = 1'b0;
        stub_wa       = n1_reg;
        stub_wd       = '0;
        stub_ra       = pick_ra;
        adj_we        = 1'b0;
        adj_wa        = n1_reg;
        adj_wd        = '0;
        adj_ra        = n1_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                stub_we = 1'b1;
                stub_wa = clr_addr_reg;
                stub_wd = '0;
                adj_we  = 1'b1;
                adj_wa  = clr_addr_reg;
                adj_wd  = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST)
                begin
                    clr_addr_next = '0;
                    status_next   = ST_CLEARED;
                    state_next    = clr_item_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request;
                    n1_next     = '0;
                    n2_next     = '0;
                    prop_next   = 1'b0;
                    status_next = ST_IGNORED;
                    state_next  = S_FINISH;
                    case (request.operation)
                        OP_CLEAR:
                        begin
                            total_next    = '0;
                            rej_next      = '0;
                            ended_next    = 1'b0;
                            clr_addr_next = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_LOAD:
                        begin
                            if (!ended_reg)
                            begin
                                status_next = ST_LOADED;
                                state_next  = S_LOAD_RD;
                            end
                        end
                        OP_PROPOSE:
                        begin
                            if (!ended_reg)
                            begin
                                prop_next = 1'b1;
                                if (may_continue)
                                begin
                                    state_next = S_PICK1;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_LOAD_RD:
            begin
                stub_ra    = IDX_W'(req_reg.node_index);
                state_next = load_in_range ? S_LOAD_WR : S_FINISH;
            end
            S_LOAD_WR:
            begin
                // The new count replaces the old one in the running total.
                stub_ra    = IDX_W'(req_reg.node_index);
                stub_we    = 1'b1;
                stub_wa    = IDX_W'(req_reg.node_index);
                stub_wd    = deg_sat;
                total_next = total_reg - TOT_W'(stub_rd) + TOT_W'(deg_sat);
                state_next = S_FINISH;
            end
            S_PICK1, S_PICK2:
            begin
                if (pick_done)
                begin
                    stub_we = take_ok;
                    stub_wa = pick_node;
                    stub_wd = taken;
                    if (take_ok && (total_reg != '0))
                    begin
                        total_next = total_reg - 1'b1;
                    end
                    if (state_reg == S_PICK1)
                    begin
                        n1_next    = pick_node;
                        v1_next    = taken;
                        state_next = S_PICK2;
                    end
                    else
                    begin
                        n2_next    = pick_node;
                        v2_next    = taken;
                        state_next = S_ADJ_RD;
                    end
                end
            end
            S_ADJ_RD:
            begin
                adj_ra     = n1_reg;
                state_next = S_ADJ_CHK;
            end
            S_ADJ_CHK:
            begin
                // Row of the first node is on the read port; fetch the second.
                adj_ra = n2_reg;
                if ((n1_reg != n2_reg) && !linked)
                begin
                    adj_we     = 1'b1;
                    adj_wa     = n1_reg;
                    adj_wd     = adj_rd | bit_n2;
                    state_next = S_ADJ_WR2;
                end
                else
                begin
                    if (rej_reg != REJ_SAT)
                    begin
                        rej_next = rej_reg + 1'b1;
                    end
                    status_next = ST_REJECTED;
                    state_next  = allow_reg ? S_REST1 : S_FINISH;
                end
            end
            S_ADJ_WR2:
            begin
                adj_ra      = n2_reg;
                adj_we      = 1'b1;
                adj_wa      = n2_reg;
                adj_wd      = adj_rd | bit_n1;
                status_next = ST_EDGE;
                state_next  = S_FINISH;
            end
            S_REST1:
            begin
                stub_we = 1'b1;
                stub_wa = n1_reg;
                if (n1_reg == n2_reg)
                begin
                    stub_wd    = same_b;
                    total_next = total_reg + TOT_W'(inc1) + TOT_W'(inc2);
                    state_next = S_FINISH;
                end
                else
                begin
                    stub_we = (v1_reg < DEG_MAX);
                    stub_wd = v1_reg + 1'b1;
                    if (v1_reg < DEG_MAX)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    state_next = S_REST2;
                end
            end
            S_REST2:
            begin
                stub_we = inc1;
                stub_wa = n2_reg;
                stub_wd = same_a;
                total_next = total_reg + TOT_W'(inc1);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // A proposal ends matching as soon as the check fails.
                ended_next = ended_reg | (prop_reg & ~may_continue);
                result_next.status         = status_reg;
                result_next.first_node     = NODE_W'(n1_reg);
                result_next.second_node    = NODE_W'(n2_reg);
                result_next.stubs_left     = STUBS_W'(total_reg);
                result_next.rejects_so_far = rej_reg;
                result_next.matching_over  = ended_next;
                result_next.restart_needed = ended_next && (total_reg > TOT_W'(2));
                done_next     = 1'b1;
                clr_item_next = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts a clearing sweep of both tables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            prop_reg     <= 1'b0;
            total_reg    <= '0;
            rej_reg      <= '0;
            ended_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
            prop_reg     <= prop_next;
            total_reg    <= total_next;
            rej_reg      <= rej_next;
            ended_reg    <= ended_next;
            done_reg     <= done_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg <= 1'b1;
            maxbt_reg <= MAX_BACKTRACKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ALLOW_BACKTRACK: allow_reg <= cfg_data[0];
                REG_MAX_BACKTRACKS:  maxbt_reg <= cfg_data;
                default:             maxbt_reg <= maxbt_reg;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/cmsm_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cmsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/cmsm_picker.sv]
// ---------------------------------------------------------------------------
// Stub picker
// Scales a random fraction by the stub total and scans the stub table, one
// entry a cycle, for the first node whose running sum exceeds the target.
// ---------------------------------------------------------------------------
module cmsm_picker #(
    parameter int NODES      = 64,
    parameter int MAX_DEGREE = 100
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         go,
    input  logic [cmsm_pkg::FRAC_W-1:0]                  frac,
    input  logic [$clog2(NODES*MAX_DEGREE+1)-1:0]        total,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]              rd_data,
    output logic [$clog2(NODES)-1:0]                     rd_addr,
    output logic                                         done,
    output logic [$clog2(NODES)-1:0]                     pick
);

    import cmsm_pkg::*;

    localparam int IDX_W  = $clog2(NODES);
    localparam int TOT_W  = $clog2(NODES * MAX_DEGREE + 1);
    localparam int RUN_W  = TOT_W + 1;
    localparam int PROD_W = TOT_W + FRAC_W;

    localparam logic P_IDLE = 1'b0;
    localparam logic P_SCAN = 1'b1;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(NODES - 1);

    logic              state_reg, state_next;
    logic              pend_reg, pend_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  chk_reg, chk_next;

    logic [TOT_W-1:0] target;
    logic [RUN_W-1:0] run_sum;
    logic             hit;

    // The scaled target is the upper part of the product.
    assign target  = prod_reg[PROD_W-1:FRAC_W];
    assign run_sum = run_reg + RUN_W'(rd_data);
    assign hit     = (run_sum > RUN_W'(target)) || (chk_reg == LAST);

    assign rd_addr = addr_reg;
    assign done    = (state_reg == P_SCAN) && pend_reg && hit;
    assign pick    = chk_reg;

    // Scan sequencer: multiply on start, then one table entry per cycle.
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        prod_next  = prod_reg;
        run_next   = run_reg;
        addr_next  = addr_reg;
        chk_next   = chk_reg;
        unique case (state_reg)
            P_IDLE:
            begin
                if (go)
                begin
                    prod_next  = PROD_W'(total) * PROD_W'(frac);
                    run_next   = '0;
                    addr_next  = '0;
                    pend_next  = 1'b0;
                    state_next = P_SCAN;
                end
            end
            P_SCAN:
            begin
                addr_next = (addr_reg == LAST) ? addr_reg : addr_reg + 1'b1;
                chk_next  = addr_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    run_next = run_sum;
                    if (hit)
                    begin
                        state_next = P_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        run_reg  <= run_next;
        addr_reg <= addr_next;
        chk_reg  <= chk_next;
    end

endmodule

[tb/sv/tb_configuration_model_stub_matcher.sv]
// ---------------------------------------------------------------------------
// Stub matcher testbench
// Drives clear, load and propose requests into the stub matcher and checks
// every result, field by field, against a behavioural model of the stub and
// adjacency tables kept in the testbench, or against the result typed in
// a short directed table, which comes first. Phases of random matching
// episodes follow, each with its own backtracking setting and sender idling.
// ---------------------------------------------------------------------------
module tb_configuration_model_stub_matcher;

    import cmsm_pkg::*;

    localparam int NODES       = 64;
    localparam int MAX_DEGREE  = 100;
    localparam int PHASE_ITEMS = 210;
    localparam int END_SETTLE  = 200;
    localparam int CYCLE_LIMIT = 2000000;

    // The fourth operation code has no meaning and must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    request_t              request;
    logic                  done;
    result_t               result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Model of the block: stub table, adjacency matrix, counters, settings.
    logic [WANT_W-1:0]  stubs_held [NODES];
    logic [NODES-1:0]   links [NODES];
    logic [STUBS_W-1:0] stub_sum;
    logic [REJ_W-1:0]   reject_tally;
    logic               matching_done;
    logic               backtrack_on;
    logic [7:0]         backtrack_cap;

    // Results still to arrive, oldest first.
    result_t     pending [$];
    result_t     oldest;
    int unsigned failures;
    int unsigned requests_sent;
    int unsigned idle_pct;
    int unsigned cycle_count;

    // Directed requests, with a typed result where one is given.
    request_t plan_req [$];
    bit       plan_typed [$];
    result_t  plan_res [$];

    configuration_model_stub_matcher #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // Prints one line for a failure and counts it.
    task automatic report_failure(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        failures++;
    endtask

    task automatic compare_field(input string field, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            report_failure($sformatf("%s is %0d, expected %0d", field, got, want));
    endtask

    // Empties every table, as a clear request or reset does.
    function automatic void wipe_model();
        for (int i = 0; i < NODES; i++)
        begin
            stubs_held[i] = '0;
            links[i]      = '0;
        end
        stub_sum      = '0;
        reject_tally  = '0;
        matching_done = 1'b0;
    endfunction

    function automatic bit may_go_on();
        int unsigned limit;
        limit = 1 + (backtrack_on ? int'(backtrack_cap) : 0);
        return (stub_sum > 3) && (reject_tally < limit);
    endfunction

    // Picks the first node whose running stub sum passes the scaled target,
    // and takes one stub from it.
    function automatic logic [NODE_W-1:0] draw_stub(input logic [FRAC_W-1:0] frac);
        logic [63:0] target;
        logic [63:0] run;
        int          pick;
        bit          found;
        target = ({51'd0, stub_sum} * {32'd0, frac}) >> 32;
        run    = '0;
        pick   = NODES - 1;
        found  = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            if (!found)
            begin
                run = run + 64'(stubs_held[i]);
                if (run > target)
                begin
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        if (stubs_held[pick] > 0)
        begin
            stubs_held[pick] = stubs_held[pick] - 1'b1;
            if (stub_sum > 0)
                stub_sum = stub_sum - 1'b1;
        end
        return pick[NODE_W-1:0];
    endfunction

    // Gives back a stub of a rejected pair, short of the degree ceiling.
    function automatic void restore_stub(input logic [NODE_W-1:0] node);
        if (stubs_held[node] < MAX_DEGREE)
        begin
            stubs_held[node] = stubs_held[node] + 1'b1;
            stub_sum         = stub_sum + 1'b1;
        end
    endfunction

    // Advances the model by one request and returns the result it predicts.
    function automatic result_t apply_request(input request_t r);
        result_t           res;
        logic [WANT_W-1:0] deg;
        res        = '0;
        res.status = ST_IGNORED;
        if (r.operation == OP_CLEAR)
        begin
            wipe_model();
            res.status = ST_CLEARED;
        end
        else if (r.operation == OP_LOAD && !matching_done)
        begin
            // Every 6-bit index names a node, so the load always lands.
            deg = (r.wanted_degree > MAX_DEGREE) ? WANT_W'(MAX_DEGREE) : r.wanted_degree;
            stub_sum = stub_sum - STUBS_W'(stubs_held[r.node_index]) + STUBS_W'(deg);
            stubs_held[r.node_index] = deg;
            res.status = ST_LOADED;
        end
        else if (r.operation == OP_PROPOSE && !matching_done)
        begin
            if (!may_go_on())
                matching_done = 1'b1;
            else
            begin
                res.first_node  = draw_stub(r.first_fraction);
                res.second_node = draw_stub(r.second_fraction);
                if (res.first_node != res.second_node
                    && !links[res.first_node][res.second_node])
                begin
                    links[res.first_node][res.second_node] = 1'b1;
                    links[res.second_node][res.first_node] = 1'b1;
                    res.status = ST_EDGE;
                end
                else
                begin
                    if (reject_tally != REJ_SAT)
                        reject_tally = reject_tally + 1'b1;
                    if (backtrack_on)
                    begin
                        restore_stub(res.first_node);
                        restore_stub(res.second_node);
                    end
                    res.status = ST_REJECTED;
                end
                if (!may_go_on())
                    matching_done = 1'b1;
            end
        end
        res.stubs_left     = stub_sum;
        res.rejects_so_far = reject_tally;
        res.matching_over  = matching_done;
        res.restart_needed = matching_done && (stub_sum > 2);
        return res;
    endfunction

    // A request with every field random, for the given operation.
    function automatic request_t random_request(input logic [OP_W-1:0] op);
        request_t r;
        r.operation       = op;
        r.node_index      = NODE_W'($urandom_range(NODES - 1));
        r.wanted_degree   = WANT_W'($urandom_range(127));
        r.first_fraction  = $urandom;
        r.second_fraction = $urandom;
        return r;
    endfunction

    // A result with no nodes chosen, as the directed table types it.
    function automatic result_t plain_result(input logic [STATUS_W-1:0] status,
                                             input int unsigned stubs,
                                             input int unsigned rejects,
                                             input bit over);
        result_t res;
        res                = '0;
        res.status         = status;
        res.stubs_left     = STUBS_W'(stubs);
        res.rejects_so_far = REJ_W'(rejects);
        res.matching_over  = over;
        return res;
    endfunction

    task automatic plan(input logic [OP_W-1:0] op, input int unsigned node,
                        input int unsigned deg, input logic [FRAC_W-1:0] f1,
                        input logic [FRAC_W-1:0] f2, input bit typed,
                        input result_t res);
        request_t r;
        r.operation       = op;
        r.node_index      = NODE_W'(node);
        r.wanted_degree   = WANT_W'(deg);
        r.first_fraction  = f1;
        r.second_fraction = f2;
        plan_req.push_back(r);
        plan_typed.push_back(typed);
        plan_res.push_back(res);
    endtask

    // Presents one request after a random idle gap and waits for it to be
    // taken. Start is left high; the next call or the drain lowers it.
    task automatic issue(input request_t r, input bit typed, input result_t typed_res);
        result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_request(r);
        if (typed)
            pending.push_back(typed_res);
        else
            pending.push_back(predicted);
        requests_sent++;
    endtask

    // Stops sending and waits until every result is in and the block is idle.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One phase of random matching episodes under one setting.
    task automatic run_phase(input bit bt, input logic [7:0] cap, input int unsigned idle);
        int unsigned phase_end;
        int unsigned nodes_in;
        int unsigned proposals;
        int unsigned roll;
        bit          dense;
        request_t    r;
        wait_idle();
        // The upper data bits of the one-bit register are junk on purpose.
        cfg_write <= 1'b1;
        cfg_index <= REG_ALLOW_BACKTRACK;
        cfg_data  <= {7'($urandom_range(127)), bt};
        @(posedge clk);
        cfg_index <= REG_MAX_BACKTRACKS;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_write <= 1'b0;
        backtrack_on  = bt;
        backtrack_cap = cap;
        idle_pct      = idle;
        phase_end     = requests_sent + PHASE_ITEMS;
        while (requests_sent < phase_end)
        begin
            // A dense episode loads a few heavy nodes, so rejects pile up.
            dense    = ($urandom_range(99) < 15);
            nodes_in = dense ? $urandom_range(2, 3) : $urandom_range(3, 20);
            issue(random_request(OP_CLEAR), 1'b0, '0);
            repeat (nodes_in)
            begin
                r = random_request(OP_LOAD);
                if (dense)
                    r.wanted_degree = WANT_W'($urandom_range(20, 127));
                else if ($urandom_range(9) != 0)
                    r.wanted_degree = WANT_W'($urandom_range(1, 8));
                issue(r, 1'b0, '0);
            end
            // Proposals until matching ends, with some noise mixed in.
            proposals = 0;
            while (!matching_done && proposals < (dense ? 300 : 80))
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    r = random_request(OP_UNUSED);
                else if (roll < 8)
                begin
                    r = random_request(OP_LOAD);
                    r.wanted_degree = WANT_W'($urandom_range(0, 6));
                end
                else if (roll < 9)
                    r = random_request(OP_CLEAR);
                else
                    r = random_request(OP_PROPOSE);
                issue(r, 1'b0, '0);
                proposals++;
            end
            // Up to two requests after the loop, which are ignored if matching is over.
            repeat ($urandom_range(2))
                issue(random_request(OP_W'($urandom_range(1, 3))), 1'b0, '0);
        end
    endtask

    // Checks each result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending.size() == 0)
                report_failure("result arrived with none expected");
            else
            begin
                oldest = pending.pop_front();
                compare_field("status", 32'(result.status), 32'(oldest.status));
                compare_field("first_node", 32'(result.first_node),
                              32'(oldest.first_node));
                compare_field("second_node", 32'(result.second_node),
                              32'(oldest.second_node));
                compare_field("stubs_left", 32'(result.stubs_left),
                              32'(oldest.stubs_left));
                compare_field("rejects_so_far", 32'(result.rejects_so_far),
                              32'(oldest.rejects_so_far));
                compare_field("matching_over", 32'(result.matching_over),
                              32'(oldest.matching_over));
                compare_field("restart_needed", 32'(result.restart_needed),
                              32'(oldest.restart_needed));
            end
        end
    end

    // Guards against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        failures      = 0;
        requests_sent = 0;
        idle_pct      = 0;
        cycle_count   = 0;
        backtrack_on  = 1'b1;
        backtrack_cap = MAX_BACKTRACKS_RST;
        wipe_model();

        // Directed table, run at the reset settings. Proposals that need the
        // stub scan worked out are left to the model.
        plan(OP_PROPOSE, 0, 0, 32'h0, 32'h0, 1, plain_result(ST_IGNORED, 0, 0, 1));
        plan(OP_LOAD, 5, 7, 32'h0, 32'h0, 1, plain_result(ST_IGNORED, 0, 0, 1));
        plan(OP_UNUSED, 0, 0, 32'h0, 32'h0, 1, plain_result(ST_IGNORED, 0, 0, 1));
        plan(OP_CLEAR, 0, 0, 32'h0, 32'h0, 1, plain_result(ST_CLEARED, 0, 0, 0));
        plan(OP_LOAD, 0, 127, 32'h0, 32'h0, 1, plain_result(ST_LOADED, 100, 0, 0));
        plan(OP_LOAD, 63, 100, 32'h0, 32'h0, 1, plain_result(ST_LOADED, 200, 0, 0));
        plan(OP_LOAD, 0, 0, 32'h0, 32'h0, 1, plain_result(ST_LOADED, 100, 0, 0));
        plan(OP_LOAD, 0, 1, 32'h0, 32'h0, 1, plain_result(ST_LOADED, 101, 0, 0));
        plan(OP_UNUSED, 63, 127, '1, '1, 1, plain_result(ST_IGNORED, 101, 0, 0));
        plan(OP_PROPOSE, 0, 0, 32'h0, 32'h0, 0, '0);
        plan(OP_PROPOSE, 0, 0, '1, '1, 0, '0);
        plan(OP_PROPOSE, 0, 0, 32'h0, '1, 0, '0);
        plan(OP_PROPOSE, 0, 0, '1, 32'h0, 0, '0);
        plan(OP_CLEAR, 0, 0, 32'h0, 32'h0, 1, plain_result(ST_CLEARED, 0, 0, 0));
        plan(OP_LOAD, 1, 2, 32'h0, 32'h0, 1, plain_result(ST_LOADED, 2, 0, 0));
        plan(OP_LOAD, 2, 2, 32'h0, 32'h0, 1, plain_result(ST_LOADED, 4, 0, 0));
        plan(OP_PROPOSE, 0, 0, 32'h0, '1, 0, '0);
        plan(OP_PROPOSE, 0, 0, 32'h0, 32'h0, 0, '0);
        plan(OP_LOAD, 3, 4, 32'h0, 32'h0, 0, '0);
        plan(OP_CLEAR, 0, 0, 32'h0, 32'h0, 1, plain_result(ST_CLEARED, 0, 0, 0));
        plan(OP_LOAD, 42, 100, 32'h0, 32'h0, 1, plain_result(ST_LOADED, 100, 0, 0));
        plan(OP_PROPOSE, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, '0);
        plan(OP_LOAD, 21, 85, 32'h0, 32'h0, 0, '0);
        plan(OP_PROPOSE, 0, 0, 32'h5555_5555, 32'hAAAA_AAAA, 0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < plan_req.size(); i++)
            issue(plan_req[i], plan_typed[i], plan_res[i]);

        // Random phases: backtracking, reject allowance and sender idling.
        run_phase(1'b1, 8'd255, 0);
        run_phase(1'b0, 8'd0, 67);
        run_phase(1'b1, 8'd0, 0);
        run_phase(1'b1, 8'($urandom_range(1, 254)), 8);
        run_phase(1'b0, 8'd255, 67);
        run_phase(1'b1, MAX_BACKTRACKS_RST, 0);

        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
